// ===== rtl/smlr_pkg.sv =====
`default_nettype none

package smlr_pkg;

    // Field and word widths
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int TDATA_W  = 2 * SAMPLE_W;

    // Signal path: 40-bit values with 16 fraction bits, Q2.30 coefficients
    localparam int SIG_W      = 40;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 30;
    localparam int PROD_W     = SIG_W + COEF_W;
    localparam int RND_W      = PROD_W - COEF_FRAC;
    localparam int SUM_W      = (RND_W > SIG_W + 3) ? RND_W : SIG_W + 3;

    // Digit-serial multiplier: coefficient digits, most significant first
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = COEF_W / DIGIT_W;
    localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PP_W       = SIG_W + DIGIT_W + 1;

    // Rounding bias, entered with the top digit so that the later shifts
    // place it at half an LSB of the rounded product.
    localparam int RND_SHIFT  = COEF_FRAC - 1 - (NUM_DIGITS - 1) * DIGIT_W;
    localparam logic [PROD_W-1:0] RND_SEED = {{(PROD_W-1){1'b0}}, 1'b1} << RND_SHIFT;

    // Output scale 0.99 as 64881/65536
    localparam int SCL_SHIFT = 2 * FRAC_W;
    localparam int SCL_Q_W   = PROD_W - SCL_SHIFT;
    localparam logic signed [COEF_W-1:0] SCALE_COEF = 32'sd64881;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_A1   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_A2   = 3'd7;

    typedef struct packed {
        logic signed [COEF_W-1:0] low_b0;
        logic signed [COEF_W-1:0] low_b1;
        logic signed [COEF_W-1:0] low_b2;
        logic signed [COEF_W-1:0] high_b0;
        logic signed [COEF_W-1:0] high_b1;
        logic signed [COEF_W-1:0] high_b2;
        logic signed [COEF_W-1:0] fb_a1;
        logic signed [COEF_W-1:0] fb_a2;
    } coef_set_t;

    // LR4 crossover coefficients
    localparam coef_set_t COEF_RESET = '{
        low_b0:  32'sd4204909,
        low_b1:  32'sd8409818,
        low_b2:  32'sd4204909,
        high_b0: 32'sd978808732,
        high_b1: -32'sd1957617463,
        high_b2: 32'sd978808732,
        fb_a1:   32'sd1949207645,
        fb_a2:   -32'sd892285457
    };

    typedef struct packed {
        logic                     start;
        logic                     rnd;
        logic signed [SIG_W-1:0]  sig;
        logic signed [COEF_W-1:0] coef;
    } mul_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] low_band;
        logic signed [SAMPLE_W-1:0] high_band;
    } result_t;

    // Mono sample as a signal word: integer part over 16 zero fraction bits
    function automatic logic signed [SIG_W-1:0] ext_mono(input logic signed [SAMPLE_W-1:0] m);
        return {{(SIG_W-SAMPLE_W-FRAC_W){m[SAMPLE_W-1]}}, m, {FRAC_W{1'b0}}};
    endfunction

    // Clamp a wide sum to the signal range
    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
        logic signed [SIG_W-1:0] lo;
        lo = v[SIG_W-1:0];
        if (v == {{(SUM_W-SIG_W){lo[SIG_W-1]}}, lo}) begin
            return lo;
        end
        return v[SUM_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
    endfunction

    // Drop the coefficient fraction (bias already added) and clamp
    function automatic logic signed [SIG_W-1:0] round_term(input logic signed [PROD_W-1:0] p);
        logic signed [RND_W-1:0] r;
        r = p[PROD_W-1:COEF_FRAC];
        return sat_sig(SUM_W'(r));
    endfunction

    // Scaled band value: truncate toward zero, clamp to a 16-bit sample
    function automatic logic signed [SAMPLE_W-1:0] scale_to_sample(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SCL_Q_W-1:0]  q;
        logic signed [SAMPLE_W-1:0] lo;
        q = p[PROD_W-1:SCL_SHIFT];
        if (p[PROD_W-1] && (p[SCL_SHIFT-1:0] != '0)) begin
            q = q + SCL_Q_W'(1);
        end
        lo = q[SAMPLE_W-1:0];
        if (q == {{(SCL_Q_W-SAMPLE_W){lo[SAMPLE_W-1]}}, lo}) begin
            return lo;
        end
        return q[SCL_Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/smlr_digit_mul.sv =====
`default_nettype none

// Signal x coefficient, one coefficient digit per cycle, top digit first.
// The product is exact; the optional bias sits at half an LSB of the
// rounded result.
module smlr_digit_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire smlr_pkg::mul_req_t req,
    output smlr_pkg::mul_rsp_t      rsp
);

    logic                                   busy_reg;
    logic [smlr_pkg::CNT_W-1:0]             cnt_reg;
    logic                                   rnd_reg;
    logic signed [smlr_pkg::SIG_W-1:0]      sig_reg;
    logic [smlr_pkg::COEF_W-1:0]            coef_sh_reg;
    logic signed [smlr_pkg::PROD_W-1:0]     acc_reg;
    logic signed [smlr_pkg::PROD_W-1:0]     acc_next;

    logic [smlr_pkg::DIGIT_W-1:0]           digit;
    logic signed [smlr_pkg::DIGIT_W:0]      digit_ext;
    logic signed [smlr_pkg::PP_W-1:0]       pp;
    logic signed [smlr_pkg::PROD_W-1:0]     pp_ext;
    logic                                   first;
    logic                                   last;

    // Partial product of the current digit; the top digit carries the sign
    always_comb begin
        digit     = coef_sh_reg[smlr_pkg::COEF_W-1 -: smlr_pkg::DIGIT_W];
        first     = (cnt_reg == '0);
        last      = (cnt_reg == smlr_pkg::CNT_W'(smlr_pkg::NUM_DIGITS - 1));
        digit_ext = first ? {digit[smlr_pkg::DIGIT_W-1], digit} : {1'b0, digit};
        pp        = sig_reg * digit_ext;
        pp_ext    = smlr_pkg::PROD_W'(pp);
        if (first) begin
            acc_next = pp_ext + (rnd_reg ? smlr_pkg::RND_SEED : '0);
        end else begin
            acc_next = (acc_reg <<< smlr_pkg::DIGIT_W) + pp_ext;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + smlr_pkg::CNT_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Operand shift register and accumulator
    always_ff @(posedge aclk) begin
        if (req.start) begin
            sig_reg     <= req.sig;
            coef_sh_reg <= req.coef;
            rnd_reg     <= req.rnd;
        end else if (busy_reg) begin
            coef_sh_reg <= coef_sh_reg << smlr_pkg::DIGIT_W;
            acc_reg     <= acc_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && last;
    assign rsp.prod = acc_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && (cnt_reg == '0))
        else $error("multiplier did not begin at the top digit");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !busy_reg)
        else $error("multiplier stayed busy after its last digit");
`endif

endmodule

`default_nettype wire

// ===== rtl/smlr_engine.sv =====
`default_nettype none

// Sequencer for the two bands: each band is two biquads of five products,
// then the 0.99 output scale. All products go through one digit-serial
// multiplier.
module smlr_engine (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [smlr_pkg::SAMPLE_W-1:0] mono,
    input  wire smlr_pkg::coef_set_t               coefs,
    input  wire logic                              res_take,
    output logic                                   ready,
    output smlr_pkg::result_t                      res
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_STORE = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Term codes within one biquad
    localparam logic [2:0] TERM_B0 = 3'd0;
    localparam logic [2:0] TERM_B1 = 3'd1;
    localparam logic [2:0] TERM_B2 = 3'd2;
    localparam logic [2:0] TERM_A1 = 3'd3;
    localparam logic [2:0] TERM_A2 = 3'd4;

    state_t     state_reg, state_next;
    logic [2:0] term_reg, term_next;
    logic       stage_reg, stage_next;   // 0: first biquad, 1: second
    logic       band_reg, band_next;     // 0: low, 1: high
    logic       scl_reg, scl_next;       // output scale product in flight

    // Mono history is the same for both bands, so it is kept once
    logic signed [smlr_pkg::SAMPLE_W-1:0] mono_cur_reg, mono_h0_reg, mono_h1_reg;
    logic signed [smlr_pkg::SIG_W-1:0]    lo_f0_reg, lo_f1_reg, lo_s0_reg, lo_s1_reg;
    logic signed [smlr_pkg::SIG_W-1:0]    hi_f0_reg, hi_f1_reg, hi_s0_reg, hi_s1_reg;
    logic signed [smlr_pkg::SIG_W-1:0]    y1_reg, y2_reg;
    logic signed [smlr_pkg::SUM_W-1:0]    sum_reg;
    logic signed [smlr_pkg::SAMPLE_W-1:0] low_out_reg, high_out_reg;

    logic signed [smlr_pkg::SIG_W-1:0]    f0_sel, f1_sel, s0_sel, s1_sel;
    logic signed [smlr_pkg::SIG_W-1:0]    term_val;
    logic signed [smlr_pkg::SIG_W-1:0]    y_sat;
    smlr_pkg::mul_req_t                   mul_req;
    smlr_pkg::mul_rsp_t                   mul_rsp;

    smlr_digit_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Band history select
    assign f0_sel = band_reg ? hi_f0_reg : lo_f0_reg;
    assign f1_sel = band_reg ? hi_f1_reg : lo_f1_reg;
    assign s0_sel = band_reg ? hi_s0_reg : lo_s0_reg;
    assign s1_sel = band_reg ? hi_s1_reg : lo_s1_reg;

    // Operand select for the next product
    always_comb begin
        mul_req.start = (state_reg == ST_ISSUE);
        mul_req.rnd   = !scl_reg;
        mul_req.sig   = '0;
        mul_req.coef  = '0;
        if (scl_reg) begin
            mul_req.sig  = y2_reg;
            mul_req.coef = smlr_pkg::SCALE_COEF;
        end else begin
            case (term_reg)
                TERM_B0: begin
                    mul_req.sig  = stage_reg ? y1_reg : smlr_pkg::ext_mono(mono_cur_reg);
                    mul_req.coef = band_reg ? coefs.high_b0 : coefs.low_b0;
                end
                TERM_B1: begin
                    mul_req.sig  = stage_reg ? f0_sel : smlr_pkg::ext_mono(mono_h0_reg);
                    mul_req.coef = band_reg ? coefs.high_b1 : coefs.low_b1;
                end
                TERM_B2: begin
                    mul_req.sig  = stage_reg ? f1_sel : smlr_pkg::ext_mono(mono_h1_reg);
                    mul_req.coef = band_reg ? coefs.high_b2 : coefs.low_b2;
                end
                TERM_A1: begin
                    mul_req.sig  = stage_reg ? s0_sel : f0_sel;
                    mul_req.coef = coefs.fb_a1;
                end
                TERM_A2: begin
                    mul_req.sig  = stage_reg ? s1_sel : f1_sel;
                    mul_req.coef = coefs.fb_a2;
                end
                default: begin
                    mul_req.sig  = '0;
                    mul_req.coef = '0;
                end
            endcase
        end
    end

    assign term_val = smlr_pkg::round_term(mul_rsp.prod);
    assign y_sat    = smlr_pkg::sat_sig(sum_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        stage_next = stage_reg;
        band_next  = band_reg;
        scl_next   = scl_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    term_next  = TERM_B0;
                    stage_next = 1'b0;
                    band_next  = 1'b0;
                    scl_next   = 1'b0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = scl_reg ? ST_SCALE : ST_ACC;
                end
            end
            ST_ACC: begin
                if (term_reg == TERM_A2) begin
                    state_next = ST_STORE;
                end else begin
                    term_next  = term_reg + 3'd1;
                    state_next = ST_ISSUE;
                end
            end
            ST_STORE: begin
                if (!stage_reg) begin
                    stage_next = 1'b1;
                    term_next  = TERM_B0;
                end else begin
                    scl_next = 1'b1;
                end
                state_next = ST_ISSUE;
            end
            ST_SCALE: begin
                scl_next = 1'b0;
                if (!band_reg) begin
                    band_next  = 1'b1;
                    stage_next = 1'b0;
                    term_next  = TERM_B0;
                    state_next = ST_ISSUE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_B0;
            stage_reg <= 1'b0;
            band_reg  <= 1'b0;
            scl_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            stage_reg <= stage_next;
            band_reg  <= band_next;
            scl_reg   <= scl_next;
        end
    end

    // Filter history, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mono_h0_reg <= '0;
            mono_h1_reg <= '0;
            lo_f0_reg   <= '0;
            lo_f1_reg   <= '0;
            lo_s0_reg   <= '0;
            lo_s1_reg   <= '0;
            hi_f0_reg   <= '0;
            hi_f1_reg   <= '0;
            hi_s0_reg   <= '0;
            hi_s1_reg   <= '0;
        end else begin
            // band history moves once the second biquad has its output
            if (state_reg == ST_STORE && stage_reg) begin
                if (band_reg) begin
                    hi_f1_reg <= hi_f0_reg;
                    hi_f0_reg <= y1_reg;
                    hi_s1_reg <= hi_s0_reg;
                    hi_s0_reg <= y_sat;
                end else begin
                    lo_f1_reg <= lo_f0_reg;
                    lo_f0_reg <= y1_reg;
                    lo_s1_reg <= lo_s0_reg;
                    lo_s0_reg <= y_sat;
                end
            end
            // mono history moves after the high band is done with it
            if (state_reg == ST_SCALE && band_reg) begin
                mono_h1_reg <= mono_h0_reg;
                mono_h0_reg <= mono_cur_reg;
            end
        end
    end

    // Working values
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            mono_cur_reg <= mono;
        end
        if (state_reg == ST_ACC) begin
            sum_reg <= (term_reg == TERM_B0) ? smlr_pkg::SUM_W'(term_val)
                                             : sum_reg + smlr_pkg::SUM_W'(term_val);
        end
        if (state_reg == ST_STORE) begin
            if (stage_reg) begin
                y2_reg <= y_sat;
            end else begin
                y1_reg <= y_sat;
            end
        end
        if (state_reg == ST_SCALE) begin
            if (band_reg) begin
                high_out_reg <= smlr_pkg::scale_to_sample(mul_rsp.prod);
            end else begin
                low_out_reg <= smlr_pkg::scale_to_sample(mul_rsp.prod);
            end
        end
    end

    assign ready         = (state_reg == ST_IDLE);
    assign res.valid     = (state_reg == ST_DONE);
    assign res.low_band  = low_out_reg;
    assign res.high_band = high_out_reg;

`ifndef SYNTHESIS
    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_WAIT))
        else $error("product arrived while sequencer was not waiting");

    a_store_after_five: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE) |-> (term_reg == TERM_A2))
        else $error("biquad sum stored before its fifth term");

    a_done_both_bands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (band_reg && !scl_reg))
        else $error("result offered before the high band was scaled");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == ST_IDLE))
        else $error("frame started while the sequencer was busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/stereo_mono_lr4_crossover_core.sv =====
`default_nettype none

// Channel   Dir  Handshake            Word
// s_        in   s_tvalid/s_tready    s_tdata: left_sample[15:0], right_sample[31:16]
// m_        out  m_tvalid/m_tready    m_tdata: low_band[15:0], high_band[31:16]
// cfg_wr_   in   cfg_wr_en            cfg_wr_index selects, cfg_wr_data[31:0] value
//
// Each frame runs 22 products on the shared multiplier, with one 40x8 digit step
// per coefficient byte plus issue and accumulate for each, then 4 biquad stores
// and a handoff through the done and idle states.
// A new frame is taken while the previous result waits in the output register.
// aresetn is synchronous: it clears all filter history and loads the LR4
// coefficients. Configuration writes take effect at once and belong between frames.
module stereo_mono_lr4_crossover_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [smlr_pkg::TDATA_W-1:0]         s_tdata,   // left_sample, right_sample
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [smlr_pkg::TDATA_W-1:0]              m_tdata,   // low_band, high_band
    input  wire logic                                 cfg_wr_en,
    input  wire logic [smlr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire logic [smlr_pkg::COEF_W-1:0]          cfg_wr_data
);

    smlr_pkg::coef_set_t                  coefs_reg;
    logic                                 m_tvalid_reg;
    logic [smlr_pkg::TDATA_W-1:0]         m_tdata_reg;

    logic signed [smlr_pkg::SAMPLE_W-1:0] left_s, right_s;
    logic signed [smlr_pkg::SAMPLE_W:0]   mix_sum, mix_adj;
    logic signed [smlr_pkg::SAMPLE_W-1:0] mono;
    logic                                 eng_ready;
    logic                                 start;
    logic                                 res_take;
    smlr_pkg::result_t                    res;

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= smlr_pkg::COEF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                smlr_pkg::REG_LOW_B0:  coefs_reg.low_b0  <= cfg_wr_data;
                smlr_pkg::REG_LOW_B1:  coefs_reg.low_b1  <= cfg_wr_data;
                smlr_pkg::REG_LOW_B2:  coefs_reg.low_b2  <= cfg_wr_data;
                smlr_pkg::REG_HIGH_B0: coefs_reg.high_b0 <= cfg_wr_data;
                smlr_pkg::REG_HIGH_B1: coefs_reg.high_b1 <= cfg_wr_data;
                smlr_pkg::REG_HIGH_B2: coefs_reg.high_b2 <= cfg_wr_data;
                smlr_pkg::REG_FB_A1:   coefs_reg.fb_a1   <= cfg_wr_data;
                smlr_pkg::REG_FB_A2:   coefs_reg.fb_a2   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Mono mix: (left + right) / 2, truncated toward zero
    always_comb begin
        left_s  = s_tdata[smlr_pkg::SAMPLE_W-1:0];
        right_s = s_tdata[smlr_pkg::TDATA_W-1:smlr_pkg::SAMPLE_W];
        mix_sum = (smlr_pkg::SAMPLE_W+1)'(left_s) + (smlr_pkg::SAMPLE_W+1)'(right_s);
        mix_adj = mix_sum + {{smlr_pkg::SAMPLE_W{1'b0}}, mix_sum[smlr_pkg::SAMPLE_W]};
        mono    = mix_adj[smlr_pkg::SAMPLE_W:1];
    end

    assign s_tready = eng_ready;
    assign start    = s_tvalid && eng_ready;

    smlr_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .mono     (mono),
        .coefs    (coefs_reg),
        .res_take (res_take),
        .ready    (eng_ready),
        .res      (res)
    );

    // Output register: loads when empty or being drained
    assign res_take = res.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= {res.high_band, res.low_band};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== verif/tb_stereo_mono_lr4_crossover_core.sv =====
`default_nettype none

module tb_stereo_mono_lr4_crossover_core;
    import smlr_pkg::*;

    localparam int WIDE_W       = 80;
    localparam int NUM_REGS     = 8;
    localparam int N_DIRECTED   = 22;
    localparam int N_PHASES     = 10;
    localparam int PHASE_FRAMES = 85;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int TAIL_CYCLES  = 300;
    localparam int MAX_REPORTS  = 100;
    localparam int LOW_PATH     = 0;
    localparam int HIGH_PATH    = 1;

    typedef logic signed [SIG_W-1:0]    sig_t;
    typedef logic signed [WIDE_W-1:0]   wide_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SAMPLE_W-1:0] pcm_t;

    localparam wide_t SIG_TOP = (wide_t'(1) <<< (SIG_W - 1)) - wide_t'(1);
    localparam wide_t SIG_BOT = -SIG_TOP - wide_t'(1);
    localparam pcm_t  S_MAX   = 16'sh7fff;
    localparam pcm_t  S_MIN   = 16'sh8000;

    typedef struct packed {
        pcm_t low;
        pcm_t high;
    } band_pair_t;

    typedef struct {
        bit         typed;
        band_pair_t bands;
    } frame_note_t;

    typedef struct packed {
        pcm_t left;
        pcm_t right;
        bit   typed;
        pcm_t low;
        pcm_t high;
    } stim_row_t;

    typedef enum int {
        SET_LR4,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_ZERO,
        SET_FULL_RANDOM,
        SET_TAME_RANDOM,
        SET_MIXED_RAILS
    } coef_set_kind_e;

    // DUT ports
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata      = '0;   // left_sample, right_sample
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;             // low_band, high_band
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [COEF_W-1:0]    cfg_wr_data  = '0;

    // Predictor state: [path][age], age 0 newest
    sig_t  mono_hist   [2][2] = '{default: '0};
    sig_t  first_hist  [2][2] = '{default: '0};
    sig_t  second_hist [2][2] = '{default: '0};
    coef_t coefs [NUM_REGS];
    coef_t plan  [NUM_REGS];

    band_pair_t  expected_bands [$];
    frame_note_t frame_notes    [$];

    int  frames_sent  = 0;
    int  results_seen = 0;
    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  src_idle_on  = 1'b1;
    bit  snk_idle_on  = 1'b1;
    bit  hold_active  = 1'b0;
    int  hold_marks [2] = '{150, 600};

    coef_set_kind_e phase_kinds [N_PHASES] = '{
        SET_ALL_MAX, SET_ALL_MIN, SET_TAME_RANDOM, SET_ZERO, SET_FULL_RANDOM,
        SET_LR4, SET_MIXED_RAILS, SET_TAME_RANDOM, SET_FULL_RANDOM, SET_LR4
    };

    // Directed frames; the first rows all mix to a zero mono sample
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{16'sd0,  16'sd0,  1'b1, 16'sd0, 16'sd0},
        '{S_MAX,   S_MIN,   1'b1, 16'sd0, 16'sd0},
        '{S_MIN,   S_MAX,   1'b1, 16'sd0, 16'sd0},
        '{-16'sd1, 16'sd0,  1'b1, 16'sd0, 16'sd0},
        '{16'sd1,  16'sd0,  1'b1, 16'sd0, 16'sd0},
        '{S_MAX,   S_MAX,   1'b0, 16'sd0, 16'sd0},
        '{S_MAX,   S_MAX,   1'b0, 16'sd0, 16'sd0},
        '{S_MAX,   S_MAX,   1'b0, 16'sd0, 16'sd0},
        '{S_MIN,   S_MIN,   1'b0, 16'sd0, 16'sd0},
        '{S_MIN,   S_MIN,   1'b0, 16'sd0, 16'sd0},
        '{S_MAX,   S_MAX,   1'b0, 16'sd0, 16'sd0},
        '{S_MIN,   S_MIN,   1'b0, 16'sd0, 16'sd0},
        '{S_MAX,   S_MAX,   1'b0, 16'sd0, 16'sd0},
        '{S_MIN,   S_MIN,   1'b0, 16'sd0, 16'sd0},
        '{16'sd0,  S_MIN,   1'b0, 16'sd0, 16'sd0},
        '{S_MIN,   16'sd0,  1'b0, 16'sd0, 16'sd0},
        '{16'sh5555, 16'sh5555, 1'b0, 16'sd0, 16'sd0},
        '{16'shaaaa, 16'shaaaa, 1'b0, 16'sd0, 16'sd0},
        '{16'sd3,  -16'sd2, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd3, 16'sd2,  1'b0, 16'sd0, 16'sd0},
        '{16'sd0,  16'sd0,  1'b0, 16'sd0, 16'sd0},
        '{16'sd0,  16'sd0,  1'b0, 16'sd0, 16'sd0}
    };

    stereo_mono_lr4_crossover_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- crossover predictor ----------------

    // Clamp to the signal range
    function automatic sig_t clamp_sig(input wide_t v);
        if (v > SIG_TOP) begin
            return SIG_TOP[SIG_W-1:0];
        end
        if (v < SIG_BOT) begin
            return SIG_BOT[SIG_W-1:0];
        end
        return v[SIG_W-1:0];
    endfunction

    // Signal times Q2.30 coefficient, round half up, clamp
    function automatic sig_t coef_term(input sig_t s, input coef_t c);
        wide_t p;
        p = wide_t'(s) * wide_t'(c);
        p = p + (wide_t'(1) <<< (COEF_FRAC - 1));
        p = p >>> COEF_FRAC;
        return clamp_sig(p);
    endfunction

    function automatic sig_t biquad_out(input sig_t x0, x1, x2, y1, y2,
                                        input coef_t b0, b1, b2);
        wide_t acc;
        acc = wide_t'(coef_term(x2, b2)) + wide_t'(coef_term(x1, b1))
            + wide_t'(coef_term(x0, b0)) + wide_t'(coef_term(y2, coefs[REG_FB_A2]))
            + wide_t'(coef_term(y1, coefs[REG_FB_A1]));
        return clamp_sig(acc);
    endfunction

    // Two cascaded sections of one band; shifts that band's history
    function automatic sig_t run_band(input int bnd, input sig_t x, input coef_t b0, b1, b2);
        sig_t y1, y2;
        y1 = biquad_out(x, mono_hist[bnd][0], mono_hist[bnd][1],
                        first_hist[bnd][0], first_hist[bnd][1], b0, b1, b2);
        y2 = biquad_out(y1, first_hist[bnd][0], first_hist[bnd][1],
                        second_hist[bnd][0], second_hist[bnd][1], b0, b1, b2);
        mono_hist[bnd][1]   = mono_hist[bnd][0];
        mono_hist[bnd][0]   = x;
        first_hist[bnd][1]  = first_hist[bnd][0];
        first_hist[bnd][0]  = y1;
        second_hist[bnd][1] = second_hist[bnd][0];
        second_hist[bnd][0] = y2;
        return y2;
    endfunction

    // Scale by 64881/65536, truncate toward zero, clamp to 16 bits
    function automatic pcm_t to_sample(input sig_t y);
        wide_t p, q;
        p = wide_t'(y) * wide_t'(SCALE_COEF);
        q = ((p < 0) ? -p : p) >>> (2 * FRAC_W);
        if (p < 0) begin
            if (q > 32768) begin
                q = 32768;
            end
            q = -q;
        end else if (q > 32767) begin
            q = 32767;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic band_pair_t crossover_step(input pcm_t l, input pcm_t r);
        logic signed [SAMPLE_W:0] pair_sum, mono;
        sig_t       x;
        band_pair_t res;
        pair_sum = l + r;
        mono     = pair_sum / 2;
        x        = sig_t'(mono) <<< FRAC_W;
        res.low  = to_sample(run_band(LOW_PATH, x, coefs[REG_LOW_B0], coefs[REG_LOW_B1],
                                      coefs[REG_LOW_B2]));
        res.high = to_sample(run_band(HIGH_PATH, x, coefs[REG_HIGH_B0], coefs[REG_HIGH_B1],
                                      coefs[REG_HIGH_B2]));
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit on);
        int roll;
        if (!on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 6);
        end
        return $urandom_range(20, 300);
    endfunction

    function automatic pcm_t draw_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return pcm_t'($urandom());
        end
        if (roll < 8) begin
            return pcm_t'($urandom_range(0, 1023) - 512);
        end
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic void build_plan(input coef_set_kind_e kind);
        case (kind)
            SET_LR4: begin
                plan[REG_LOW_B0]  = COEF_RESET.low_b0;
                plan[REG_LOW_B1]  = COEF_RESET.low_b1;
                plan[REG_LOW_B2]  = COEF_RESET.low_b2;
                plan[REG_HIGH_B0] = COEF_RESET.high_b0;
                plan[REG_HIGH_B1] = COEF_RESET.high_b1;
                plan[REG_HIGH_B2] = COEF_RESET.high_b2;
                plan[REG_FB_A1]   = COEF_RESET.fb_a1;
                plan[REG_FB_A2]   = COEF_RESET.fb_a2;
            end
            SET_ALL_MAX: begin
                foreach (plan[i]) plan[i] = 32'sh7fff_ffff;
            end
            SET_ALL_MIN: begin
                foreach (plan[i]) plan[i] = 32'sh8000_0000;
            end
            SET_ZERO: begin
                foreach (plan[i]) plan[i] = '0;
            end
            SET_FULL_RANDOM: begin
                foreach (plan[i]) plan[i] = coef_t'($urandom());
            end
            SET_TAME_RANDOM: begin
                // feed-forward within +-1.0, feedback kept small
                foreach (plan[i]) plan[i] = coef_t'($urandom_range(0, 32'h7fff_ffff))
                                            - 32'sh4000_0000;
                plan[REG_FB_A1] = coef_t'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
                plan[REG_FB_A2] = coef_t'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
            end
            default: begin
                plan[REG_LOW_B0]  = 32'sh7fff_ffff;
                plan[REG_LOW_B1]  = 32'sh8000_0000;
                plan[REG_LOW_B2]  = 32'sh7fff_ffff;
                plan[REG_HIGH_B0] = 32'sh8000_0000;
                plan[REG_HIGH_B1] = 32'sh7fff_ffff;
                plan[REG_HIGH_B2] = 32'sh8000_0000;
                plan[REG_FB_A1]   = 32'sh7fff_ffff;
                plan[REG_FB_A2]   = 32'sh8000_0000;
            end
        endcase
    endfunction

    // Write all eight registers back to back; block must be idle
    task automatic apply_coef_set(input coef_set_kind_e kind);
        build_plan(kind);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= CFG_IDX_W'(i);
            cfg_wr_data  <= plan[i];
            coefs[i]      = plan[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one frame word and return at the edge it is taken
    task automatic send_frame(input pcm_t l, input pcm_t r, input bit typed,
                              input band_pair_t bands);
        int          gap;
        frame_note_t note;
        gap = hold_active ? 0 : pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        note.typed = typed;
        note.bands = bands;
        frame_notes.push_back(note);
        s_tdata  <= {r, l};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frames_sent++;
    endtask

    task automatic wait_drained();
        while (results_seen < frames_sent) @(posedge aclk);
    endtask

    // ---------------- main sequence ----------------
    initial begin : main_seq
        pcm_t l, r;
        build_plan(SET_LR4);
        coefs = plan;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames on reset coefficients
        foreach (directed_rows[i]) begin
            send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed,
                       '{directed_rows[i].low, directed_rows[i].high});
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // random frames, one coefficient set per phase
        foreach (phase_kinds[p]) begin
            apply_coef_set(phase_kinds[p]);
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                l = draw_sample();
                r = draw_sample();
                send_frame(l, r, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_bands.size() == 0) begin
            $display("tb_stereo_mono_lr4_crossover_core: clean");
        end else begin
            $display("tb_stereo_mono_lr4_crossover_core: errors");
        end
        $finish;
    end

    // ---------------- result receiver ----------------
    initial begin : sink
        int stall;
        int holds_done;
        stall      = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            // long hold-off so the block fills and stalls its input
            if (holds_done < 2 && results_seen >= hold_marks[holds_done]) begin
                hold_active = 1'b1;
                m_tready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
                holds_done++;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (aresetn && $urandom_range(0, 31) == 0) begin
                    stall = pick_gap(snk_idle_on);
                end
            end
        end
    end

    // ---------------- monitors ----------------
    always @(posedge aclk) begin : monitor
        frame_note_t note;
        band_pair_t  want, got;
        if (aresetn) begin
            // predict on each accepted input word
            if (s_tvalid && s_tready) begin
                note = frame_notes.pop_front();
                want = crossover_step(s_tdata[SAMPLE_W-1:0], s_tdata[TDATA_W-1:SAMPLE_W]);
                expected_bands.push_back(note.typed ? note.bands : want);
            end
            // compare each accepted result word
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.low  = m_tdata[SAMPLE_W-1:0];
                got.high = m_tdata[TDATA_W-1:SAMPLE_W];
                if (expected_bands.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $error("unexpected result word: low_band %0d, high_band %0d",
                               got.low, got.high);
                    end
                end else begin
                    want = expected_bands.pop_front();
                    if (got.low !== want.low) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $error("low_band: expected %0d, got %0d", want.low, got.low);
                        end
                    end
                    if (got.high !== want.high) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $error("high_band: expected %0d, got %0d", want.high, got.high);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_stereo_mono_lr4_crossover_core: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/smlr_pkg.sv
rtl/smlr_digit_mul.sv
rtl/smlr_engine.sv
rtl/stereo_mono_lr4_crossover_core.sv
verif/tb_stereo_mono_lr4_crossover_core.sv
